// File: hw/rtl/bstk_pkg.sv
// Shared types and codes for the bounded stack with indexed access.
package bstk_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_POS  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WRITE_POS = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DUMP      = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] push_value;
    logic [POS_W-1:0]         position;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] read_data;
    logic [DEPTH_W-1:0]       depth_now;
    logic                     last;
  } out_t;

  // What one cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT,
    CELL_TAKE_NEW
  } cell_op_t;

endpackage

// File: hw/rtl/bounded_stack_with_indexed_access.sv
// Top level of the bounded stack: cell chain, fill count and result register.
//
//   channel | ports                         | transfer when
//   --------+-------------------------------+----------------------------
//   input   | in_valid, in_ready, in_data   | in_valid && in_ready
//   result  | out_valid, out_ready, out_data| out_valid && out_ready
//
// Every operation but a dump of a non-empty stack yields one result transfer.
// Such a dump yields one result per held entry, one per cycle while the result
// register drains; the cell chain rotates once per result, so a dump keeps
// the input closed until its last result is loaded into the result register.
// Reset (rst_n low at a clock edge) empties the stack and drops any result.
// A stalled result register holds its item; a new input is taken in the
// same cycle the waiting result transfers.
module bounded_stack_with_indexed_access #(
  parameter int DEPTH      = bstk_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bstk_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bstk_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bstk_pkg::out_t out_data
);
  import bstk_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    S_RUN,
    S_DUMP
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;     // entries held
  logic [CNT_W-1:0]   rem_r, rem_nxt;     // dump results still to send
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  // Cell 0 is the top of the stack; entry k from the top sits in cell k-1.
  logic [DATA_WIDTH-1:0] cell_q    [DEPTH];
  logic [DATA_WIDTH-1:0] next_in   [DEPTH];
  logic [DATA_WIDTH-1:0] prev_in   [DEPTH];
  cell_op_t              cell_op   [DEPTH];
  logic [DATA_WIDTH-1:0] new_word;
  logic                  rotate;
  logic                  slot_free;
  logic                  in_fire;
  logic                  pos_ok;
  logic [IDX_W-1:0]      pos_idx;

  // Word as stored: sign-extend or truncate the incoming 32-bit value.
  assign new_word = DATA_WIDTH'(in_data.push_value);
  assign pos_idx  = IDX_W'(in_data.position - 8'd1);
  assign pos_ok   = (in_data.position != '0) &&
                    (9'(in_data.position) <= 9'(cnt_r));

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_RUN) && slot_free;
  assign in_fire   = in_valid && in_ready;

  // Neighbor wiring. On a push each cell takes the one above it (the top
  // takes the new word); on a pop each takes the one below. During a dump
  // the held entries rotate, with the deepest one taking the top word.
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_top
        assign prev_in[g] = new_word;
      end else begin : g_mid
        assign prev_in[g] = cell_q[g-1];
      end
      assign next_in[g] = (rotate && (CNT_W'(g + 1) == cnt_r)) ? cell_q[0]
                                                                 : cell_q[(g + 1) % DEPTH];
      bstk_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk       (clk),
        .op        (cell_op[g]),
        .prev_data (prev_in[g]),
        .next_data (next_in[g]),
        .new_data  (new_word),
        .cell_data (cell_q[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    rotate        = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
    end

    if (in_fire) begin
      out_valid_nxt     = 1'b1;
      out_nxt.status    = STATUS_OK;
      out_nxt.read_data = '0;
      out_nxt.last      = 1'b1;
      case (in_data.kind)
        KIND_PUSH: begin
          if (cnt_r == CNT_W'(DEPTH)) begin
            out_nxt.status = STATUS_OVERFLOW;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              cell_op[i] = CELL_TAKE_PREV;
            end
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        KIND_POP: begin
          if (cnt_r == '0) begin
            out_nxt.status = STATUS_EMPTY;
          end else begin
            out_nxt.read_data = WORD_W'(cell_q[0]);
            for (int i = 0; i < DEPTH; i++) begin
              cell_op[i] = CELL_TAKE_NEXT;
            end
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        KIND_PEEK: begin
          if (cnt_r == '0) begin
            out_nxt.status = STATUS_EMPTY;
          end else begin
            out_nxt.read_data = WORD_W'(cell_q[0]);
          end
        end
        KIND_READ_POS: begin
          if (!pos_ok) begin
            out_nxt.status = STATUS_BAD_POS;
          end else begin
            out_nxt.read_data = WORD_W'(cell_q[pos_idx]);
          end
        end
        KIND_WRITE_POS: begin
          if (!pos_ok) begin
            out_nxt.status = STATUS_BAD_POS;
          end else begin
            cell_op[pos_idx] = CELL_TAKE_NEW;
          end
        end
        KIND_DUMP: begin
          if (cnt_r == '0) begin
            out_nxt.status = STATUS_EMPTY;
          end else begin
            // Send the top now and rotate; the rest follow from cell 0.
            out_nxt.read_data = WORD_W'(cell_q[0]);
            rotate = 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              if (CNT_W'(i) < cnt_r) begin
                cell_op[i] = CELL_TAKE_NEXT;
              end
            end
            if (cnt_r != CNT_W'(1)) begin
              out_nxt.last = 1'b0;
              rem_nxt      = cnt_r - 1'b1;
              state_nxt    = S_DUMP;
            end
          end
        end
        default: begin
          // Unused codes: report ok, leave the stack alone.
        end
      endcase
      out_nxt.depth_now = DEPTH_W'(cnt_nxt);
    end else if (state_r == S_DUMP && slot_free) begin
      out_valid_nxt     = 1'b1;
      out_nxt.status    = STATUS_OK;
      out_nxt.read_data = WORD_W'(cell_q[0]);
      out_nxt.depth_now = DEPTH_W'(cnt_r);
      out_nxt.last      = (rem_r == CNT_W'(1));
      rotate            = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
        if (CNT_W'(i) < cnt_r) begin
          cell_op[i] = CELL_TAKE_NEXT;
        end
      end
      rem_nxt = rem_r - 1'b1;
      if (rem_r == CNT_W'(1)) begin
        state_nxt = S_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/bstk_cell.sv
// One stack cell: holds a word and loads from a neighbor or the write port.
module bstk_cell #(
  parameter int DATA_WIDTH = bstk_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  bstk_pkg::cell_op_t       op,
  input  logic [DATA_WIDTH-1:0]    prev_data,
  input  logic [DATA_WIDTH-1:0]    next_data,
  input  logic [DATA_WIDTH-1:0]    new_data,
  output logic [DATA_WIDTH-1:0]    cell_data
);
  import bstk_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    case (op)
      CELL_HOLD:      data_nxt = data_r;
      CELL_TAKE_PREV: data_nxt = prev_data;
      CELL_TAKE_NEXT: data_nxt = next_data;
      CELL_TAKE_NEW:  data_nxt = new_data;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign cell_data = data_r;

endmodule

// File: bench/tb_bounded_stack_with_indexed_access.sv
// Self-checking testbench for the bounded stack with indexed access.
`timescale 1ns / 1ps

module tb_bounded_stack_with_indexed_access;
  import bstk_pkg::*;

  localparam int STACK_DEPTH = DEPTH_DEF;
  // Spare operation codes: the block answers them with a plain ok and no change.
  localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;
  // Worst case per item is a full dump: 16 results, each behind a result
  // stall, plus a sender idle gap.
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_CYCLES = 40;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data  = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  bounded_stack_with_indexed_access uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the stack, updated as each operation is accepted.
  logic signed [WORD_W-1:0] stack_words [STACK_DEPTH];
  int unsigned              stack_fill = 0;
  out_t                     pending_results [$];
  out_t                     oldest_expected;

  bit idle_on      = 1'b1;
  int stall_left   = 0;
  int error_count  = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int dump_count   = 0;
  int overflow_count = 0;
  int deepest_fill = 0;
  int cycle_count  = 0;

  // Work out the result transfers of one accepted operation and queue them.
  task automatic predict_stack_op(input in_t op);
    out_t        r;
    int unsigned idx;
    r      = '0;
    r.last = 1'b1;
    case (op.kind)
      KIND_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          r.status = STATUS_OVERFLOW;
          overflow_count++;
        end else begin
          stack_words[stack_fill] = op.push_value;
          stack_fill++;
        end
      end
      KIND_POP: begin
        if (stack_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          stack_fill--;
          r.read_data = stack_words[stack_fill];
        end
      end
      KIND_PEEK: begin
        if (stack_fill == 0) r.status = STATUS_EMPTY;
        else r.read_data = stack_words[stack_fill - 1];
      end
      KIND_READ_POS, KIND_WRITE_POS: begin
        if (op.position == 0 || op.position > stack_fill) begin
          r.status = STATUS_BAD_POS;
        end else begin
          idx = stack_fill - op.position;
          if (op.kind == KIND_READ_POS) r.read_data = stack_words[idx];
          else stack_words[idx] = op.push_value;
        end
      end
      KIND_DUMP: begin
        if (stack_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          // One transfer per entry, top first; last marks the bottom entry.
          dump_count++;
          r.depth_now = DEPTH_W'(stack_fill);
          for (idx = stack_fill; idx > 0; idx--) begin
            r.read_data = stack_words[idx - 1];
            r.last      = (idx == 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.depth_now = DEPTH_W'(stack_fill);
    pending_results.push_back(r);
    if (stack_fill > deepest_fill) deepest_fill = stack_fill;
  endtask

  // Offer one operation and hold it until the block takes it. Valid stays
  // high after the transfer so back-to-back items need no extra edge.
  task automatic send_op(input logic [KIND_W-1:0] kind,
                         input logic signed [WORD_W-1:0] value,
                         input logic [POS_W-1:0] pos);
    in_t op;
    op.kind       = kind;
    op.push_value = value;
    op.position   = pos;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_data  <= op;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_stack_op(op);
    items_sent++;
  endtask

  // Lower valid and wait until every queued result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly land inside the valid range; otherwise hit its edges or anywhere.
  function automatic logic [POS_W-1:0] random_position();
    if (stack_fill > 0 && $urandom_range(0, 9) < 7)
      return POS_W'($urandom_range(1, stack_fill));
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return POS_W'(stack_fill + 1);
      default: return POS_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Pick one operation; push_weight steers the stack toward full or empty.
  task automatic send_random_op(input int push_weight);
    int r;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(0, 99);
    if (r < push_weight)  kind = KIND_PUSH;
    else if (r < 70)      kind = KIND_POP;
    else if (r < 77)      kind = KIND_PEEK;
    else if (r < 85)      kind = KIND_READ_POS;
    else if (r < 93)      kind = KIND_WRITE_POS;
    else if (r < 98)      kind = KIND_DUMP;
    else if (r == 98)     kind = KIND_SPARE_6;
    else                  kind = KIND_SPARE_7;
    send_op(kind, random_word(), random_position());
  endtask

  task automatic test_empty_stack();
    send_op(KIND_POP, 32'sd0, 8'd0);
    send_op(KIND_PEEK, 32'sd0, 8'd0);
    send_op(KIND_DUMP, 32'sd0, 8'd0);
    send_op(KIND_READ_POS, 32'sd0, 8'd1);
    send_op(KIND_WRITE_POS, 32'hFFFF_FFFF, 8'd0);
    send_op(KIND_SPARE_6, 32'h7FFF_FFFF, 8'd255);
    send_op(KIND_SPARE_7, 32'h8000_0000, 8'd0);
  endtask

  task automatic test_fill_to_overflow();
    logic signed [WORD_W-1:0] corner_words [7];
    corner_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h1};
    for (int i = 0; i < STACK_DEPTH; i++)
      send_op(KIND_PUSH, (i < 7) ? corner_words[i] : $urandom, 8'd0);
    send_op(KIND_PUSH, $urandom, 8'd0);
  endtask

  task automatic test_positions_when_full();
    send_op(KIND_READ_POS, 32'sd0, 8'd16);
    send_op(KIND_READ_POS, 32'sd0, 8'd17);
    send_op(KIND_READ_POS, 32'sd0, 8'd255);
    send_op(KIND_WRITE_POS, 32'h8000_0001, 8'd1);
    send_op(KIND_WRITE_POS, 32'h7FFF_FFFE, 8'd16);
    send_op(KIND_DUMP, 32'sd0, 8'd0);
  endtask

  // Alternate fill-heavy and drain-heavy stretches so the stack keeps
  // swinging between empty and full; idling switches on and off per stretch.
  task automatic test_random_traffic(input int count);
    int push_weight;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        push_weight = ((i / 30) % 2 == 0) ? 55 : 25;
        idle_on     = ($urandom_range(0, 3) != 0);
      end
      send_random_op(push_weight);
    end
  endtask

  // Let the block go quiet, then resume against a fully drained result path.
  task automatic test_drain_pause();
    wait_drained();
    send_op(KIND_PEEK, 32'sd0, 8'd0);
    send_op(KIND_DUMP, 32'sd0, 8'd0);
  endtask

  // Closing stretch: no idling on either side.
  task automatic test_steady_stream(input int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) send_random_op((i / 25) % 2 == 0 ? 55 : 25);
  endtask

  // Result side: stall in bursts of random length while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: status %0d read_data %0d depth_now %0d last %0b",
               out_data.status, out_data.read_data, out_data.depth_now, out_data.last);
        error_count++;
      end else begin
        oldest_expected = pending_results.pop_front();
        if (out_data.status !== oldest_expected.status) begin
          $error("status: expected %0d, got %0d", oldest_expected.status, out_data.status);
          error_count++;
        end
        if (out_data.read_data !== oldest_expected.read_data) begin
          $error("read_data: expected %0d, got %0d",
                 oldest_expected.read_data, out_data.read_data);
          error_count++;
        end
        if (out_data.depth_now !== oldest_expected.depth_now) begin
          $error("depth_now: expected %0d, got %0d",
                 oldest_expected.depth_now, out_data.depth_now);
          error_count++;
        end
        if (out_data.last !== oldest_expected.last) begin
          $error("last: expected %0b, got %0b", oldest_expected.last, out_data.last);
          error_count++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("tb_bounded_stack_with_indexed_access: errors");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_fill_to_overflow();
    test_positions_when_full();
    test_random_traffic(150);
    test_drain_pause();
    test_random_traffic(150);
    test_steady_stream(130);

    // Drain the result path, then watch for stray transfers.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d operations and %0d result transfers: %0d dumps, %0d overflow pushes",
             items_sent, results_seen, dump_count, overflow_count);
    $display("stack fill reached %0d of %0d entries", deepest_fill, STACK_DEPTH);
    if (error_count == 0) begin
      $display("tb_bounded_stack_with_indexed_access: clean");
    end else begin
      $display("tb_bounded_stack_with_indexed_access: errors");
    end
    $finish;
  end

endmodule
